### rtl/core/intel_hex_record_parser_assert.svh
// ============================================================================
// intel_hex_record_parser_assert.svh
// assertion macros used by the intel hex record parser checker
// ============================================================================
`ifndef INTEL_HEX_RECORD_PARSER_ASSERT_SVH
`define INTEL_HEX_RECORD_PARSER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define IHEX_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define IHEX_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/ihex_pkg.sv
// ============================================================================
// ihex_pkg
// shared codes and the hex digit decoder of the intel hex record parser
// ============================================================================
`default_nettype none

package ihex_pkg;

    // result status codes
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_MORE   = 2'd1;
    localparam logic [1:0] ST_SUMERR = 2'd2;
    localparam logic [1:0] ST_SEQERR = 2'd3;

    // parser phases
    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_COUNT = 3'd1;
    localparam logic [2:0] PH_ADDR  = 3'd2;
    localparam logic [2:0] PH_TYPE  = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_SUM   = 3'd5;
    localparam logic [2:0] PH_END   = 3'd6;
    localparam logic [2:0] PH_DONE  = 3'd7;

    // special characters
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;

    // decoded hex digit: valid flag and nibble value
    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] ch);
        hex_digit_t d;
        logic [7:0] diff;
        d.valid = 1'b0;
        d.value = 4'd0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            diff    = ch - 8'h30;
            d.valid = 1'b1;
            d.value = diff[3:0];
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            diff    = ch - 8'h57;
            d.valid = 1'b1;
            d.value = diff[3:0];
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            diff    = ch - 8'h37;
            d.valid = 1'b1;
            d.value = diff[3:0];
        end
        return d;
    endfunction

endpackage

`default_nettype wire

### rtl/core/intel_hex_record_parser.sv
// ============================================================================
// intel_hex_record_parser
// parses an ascii intel hex stream into byte writes and a running status
// ============================================================================
// The parser takes one character per clock cycle and returns one result for
// each character from its output register in the cycle after it is
// accepted. The whole per-character update (hex decode, field shift, byte
// add into the checksum, phase change) is one pass of logic into the state
// and result registers, so a new character is taken in every cycle while the
// result side keeps up; s_ready drops only while a result sits in the output
// register and m_ready is low. Data bytes of type 0 records come out with
// m_write_valid set at an address that starts at the record address and
// wraps at 16 bits. Checksum and sequence errors, and the end of the stream,
// are sticky: every later character gets the same status.
`default_nettype none

module intel_hex_record_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // character input
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_character,
    // result output
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic             m_write_valid,
    output logic [15:0]      m_write_address,
    output logic [7:0]       m_write_data
);

    // parser state
    logic [2:0]  phase_reg,        phase_next;
    logic [2:0]  digit_count_reg,  digit_count_next;
    logic [15:0] field_value_reg,  field_value_next;
    logic [7:0]  bytes_left_reg,   bytes_left_next;
    logic [15:0] next_address_reg, next_address_next;
    logic [7:0]  running_sum_reg,  running_sum_next;
    logic [1:0]  last_status_reg,  last_status_next;

    // output register
    logic        out_valid_reg;
    logic [1:0]  out_status_reg;
    logic        out_wv_reg;
    logic [15:0] out_wa_reg;
    logic [7:0]  out_wd_reg;

    // per-character result
    logic [1:0]  res_status;
    logic        res_wv;
    logic [15:0] res_wa;
    logic [7:0]  res_wd;

    // digit handling
    ihex_pkg::hex_digit_t hex;
    logic [15:0] shifted;
    logic [2:0]  count_inc;
    logic [7:0]  byte_val;
    logic        byte_done;
    logic        word_done;
    logic [7:0]  bytes_dec;
    logic [7:0]  sum_check;
    logic        accept;

    // handshake
    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // digit shift and field completion
    assign hex       = ihex_pkg::hex_decode(s_character);
    assign shifted   = {field_value_reg[11:0], hex.value};
    assign count_inc = digit_count_reg + 3'd1;
    assign byte_val  = shifted[7:0];
    assign byte_done = hex.valid && (count_inc >= 3'd2);
    assign word_done = hex.valid && (count_inc >= 3'd4);
    assign bytes_dec = bytes_left_reg - 8'd1;
    assign sum_check = running_sum_reg + byte_val;

    // next state and result
    always_comb begin
        phase_next        = phase_reg;
        digit_count_next  = digit_count_reg;
        field_value_next  = field_value_reg;
        bytes_left_next   = bytes_left_reg;
        next_address_next = next_address_reg;
        running_sum_next  = running_sum_reg;
        res_status        = ihex_pkg::ST_MORE;
        res_wv            = 1'b0;
        res_wa            = 16'd0;
        res_wd            = 8'd0;

        // collect digits in every field phase
        if (phase_reg != ihex_pkg::PH_START && phase_reg != ihex_pkg::PH_DONE
                && hex.valid) begin
            field_value_next = shifted;
            digit_count_next = count_inc;
        end

        unique case (phase_reg)
            ihex_pkg::PH_START: begin
                if (s_character == ihex_pkg::CH_COLON) begin
                    phase_next       = ihex_pkg::PH_COUNT;
                    digit_count_next = 3'd0;
                    field_value_next = 16'd0;
                    running_sum_next = 8'd0;
                end else if (s_character != ihex_pkg::CH_CR
                        && s_character != ihex_pkg::CH_LF) begin
                    phase_next = ihex_pkg::PH_DONE;
                    res_status = ihex_pkg::ST_SEQERR;
                end
            end
            ihex_pkg::PH_COUNT: begin
                if (byte_done) begin
                    bytes_left_next  = byte_val;
                    running_sum_next = sum_check;
                    phase_next       = ihex_pkg::PH_ADDR;
                    digit_count_next = 3'd0;
                    field_value_next = 16'd0;
                end
            end
            ihex_pkg::PH_ADDR: begin
                if (word_done) begin
                    next_address_next = shifted;
                    running_sum_next  = running_sum_reg + shifted[15:8] + shifted[7:0];
                    phase_next        = ihex_pkg::PH_TYPE;
                    digit_count_next  = 3'd0;
                    field_value_next  = 16'd0;
                end
            end
            ihex_pkg::PH_TYPE: begin
                if (byte_done) begin
                    running_sum_next = sum_check;
                    if (byte_val != 8'd0) begin
                        phase_next = ihex_pkg::PH_END;
                    end else if (bytes_left_reg == 8'd0) begin
                        phase_next = ihex_pkg::PH_SUM;
                    end else begin
                        phase_next = ihex_pkg::PH_DATA;
                    end
                    digit_count_next = 3'd0;
                    field_value_next = 16'd0;
                end
            end
            ihex_pkg::PH_DATA: begin
                if (byte_done) begin
                    running_sum_next  = sum_check;
                    res_wv            = 1'b1;
                    res_wa            = next_address_reg;
                    res_wd            = byte_val;
                    next_address_next = next_address_reg + 16'd1;
                    bytes_left_next   = bytes_dec;
                    if (bytes_dec == 8'd0) begin
                        phase_next = ihex_pkg::PH_SUM;
                    end
                    digit_count_next = 3'd0;
                    field_value_next = 16'd0;
                end
            end
            ihex_pkg::PH_SUM: begin
                if (byte_done) begin
                    if (sum_check != 8'd0) begin
                        phase_next = ihex_pkg::PH_DONE;
                        res_status = ihex_pkg::ST_SUMERR;
                    end else begin
                        phase_next        = ihex_pkg::PH_START;
                        bytes_left_next   = 8'd0;
                        next_address_next = 16'd0;
                        running_sum_next  = 8'd0;
                    end
                    digit_count_next = 3'd0;
                    field_value_next = 16'd0;
                end
            end
            ihex_pkg::PH_END: begin
                if (byte_done) begin
                    phase_next       = ihex_pkg::PH_DONE;
                    res_status       = ihex_pkg::ST_DONE;
                    digit_count_next = 3'd0;
                    field_value_next = 16'd0;
                end
            end
            ihex_pkg::PH_DONE: begin
                // stream finished: repeat the status that ended it
                res_status = last_status_reg;
            end
        endcase

        last_status_next = res_status;
    end

    // state registers, updated on each accepted character
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= ihex_pkg::PH_START;
            digit_count_reg  <= 3'd0;
            field_value_reg  <= 16'd0;
            bytes_left_reg   <= 8'd0;
            next_address_reg <= 16'd0;
            running_sum_reg  <= 8'd0;
            last_status_reg  <= ihex_pkg::ST_DONE;
        end else if (accept) begin
            phase_reg        <= phase_next;
            digit_count_reg  <= digit_count_next;
            field_value_reg  <= field_value_next;
            bytes_left_reg   <= bytes_left_next;
            next_address_reg <= next_address_next;
            running_sum_reg  <= running_sum_next;
            last_status_reg  <= last_status_next;
        end
    end

    // output valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_status_reg <= res_status;
            out_wv_reg     <= res_wv;
            out_wa_reg     <= res_wa;
            out_wd_reg     <= res_wd;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = out_status_reg;
    assign m_write_valid   = out_wv_reg;
    assign m_write_address = out_wa_reg;
    assign m_write_data    = out_wd_reg;

endmodule

`default_nettype wire

### rtl/core/ihex_checker.sv
// ============================================================================
// ihex_checker
// port-level checks of the intel hex record parser result channel
// ============================================================================
`default_nettype none

`include "intel_hex_record_parser_assert.svh"

module ihex_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_status,
    input wire logic        m_write_valid,
    input wire logic [15:0] m_write_address,
    input wire logic [7:0]  m_write_data
);

    logic       final_seen_reg;
    logic [1:0] final_status_reg;

    // remember the first status that ends the stream
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            final_seen_reg   <= 1'b0;
            final_status_reg <= ihex_pkg::ST_DONE;
        end else if (m_valid && m_ready && !final_seen_reg
                && m_status != ihex_pkg::ST_MORE) begin
            final_seen_reg   <= 1'b1;
            final_status_reg <= m_status;
        end
    end

    // a byte write only comes with a record still in progress
    `IHEX_ASSERT_IMPLY(a_write_needs_more, aclk, aresetn, m_valid && m_write_valid, m_status == ihex_pkg::ST_MORE, "write with final status")

    // idle write fields read as zero
    `IHEX_ASSERT_IMPLY(a_idle_write_zero, aclk, aresetn, m_valid && !m_write_valid, m_write_address == 16'd0 && m_write_data == 8'd0, "nonzero idle write fields")

    // once the stream has ended the status stays and no writes follow
    `IHEX_ASSERT_IMPLY(a_sticky_end, aclk, aresetn, m_valid && final_seen_reg, m_status == final_status_reg && !m_write_valid, "end status not sticky")

    // a stalled result holds
    `IHEX_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_write_valid) && $stable(m_write_address) && $stable(m_write_data), "stalled result changed")

endmodule

bind intel_hex_record_parser ihex_checker u_ihex_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_write_valid   (m_write_valid),
    .m_write_address (m_write_address),
    .m_write_data    (m_write_data)
);

`default_nettype wire

### tb/sv/tb_top.sv
// ============================================================================
// tb_top
// self-checking testbench for the intel hex record parser
// ============================================================================
// A character stream is built up front: a few hand-picked records (line
// breaks, a zero-count record at the top address, a record whose data wraps
// the address), then many well-formed type 0 records with random counts,
// addresses, digit case and stray non-hex characters. The stream ends one of
// three ways, picked at random per run: an end record, a bad checksum or a
// stray character at record start. Noise follows to check that the final
// status sticks. A clocked driver offers the characters, a clocked monitor
// checks every result against a local parser model, and both sides idle in
// phases.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AT       = 600;
    localparam int PHASE_LEN     = 150;
    localparam int RANDOM_TARGET = 1480;

    // how the stream is terminated
    typedef enum int {
        END_RECORD,
        END_BAD_SUM,
        END_STRAY_CHAR
    } stream_end_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        write_valid;
        logic [15:0] write_address;
        logic [7:0]  write_data;
    } parse_result_t;

    typedef struct {
        logic [7:0] ch;
        bit         drain;
    } char_item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_character = 8'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic        m_write_valid;
    logic [15:0] m_write_address;
    logic [7:0]  m_write_data;

    intel_hex_record_parser u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_character     (s_character),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_write_valid   (m_write_valid),
        .m_write_address (m_write_address),
        .m_write_data    (m_write_data)
    );

    char_item_t    char_q[$];
    parse_result_t expected_q[$];

    int          chars_sent = 0;
    int          results_seen = 0;
    int          writes_seen = 0;
    int          error_count = 0;
    int          record_count = 0;
    int          filler_pct = 0;
    bit          drain_next = 1'b0;
    logic [1:0]  last_seen_status = ihex_pkg::ST_MORE;
    stream_end_t stream_end;

    // local parser state
    logic [2:0]  pr_phase;
    logic [2:0]  pr_digits;
    logic [15:0] pr_field;
    logic [7:0]  pr_left;
    logic [15:0] pr_addr;
    logic [7:0]  pr_sum;
    logic [1:0]  pr_last;

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------------

    // returns {is_digit, nibble}
    function automatic logic [4:0] digit_of(input logic [7:0] ch);
        logic [7:0] folded;
        folded = ch | 8'h20;
        if (ch >= "0" && ch <= "9")
            return {1'b1, ch[3:0]};
        else if (folded >= "a" && folded <= "f")
            return {1'b1, ch[3:0] + 4'd9};
        return 5'd0;
    endfunction

    // shifts one nibble into the field, true once the field is complete
    function automatic logic shift_digit(input logic [3:0] nib, input logic [2:0] wanted);
        pr_field  = {pr_field[11:0], nib};
        pr_digits = pr_digits + 3'd1;
        return pr_digits >= wanted;
    endfunction

    function automatic parse_result_t predict_char(input logic [7:0] ch);
        parse_result_t r;
        logic [4:0]    nib;
        logic [7:0]    b;
        logic [7:0]    total;
        r        = '0;
        r.status = ihex_pkg::ST_MORE;
        nib      = digit_of(ch);
        b        = pr_field[7:0];
        case (pr_phase)
            ihex_pkg::PH_START: begin
                if (ch == ihex_pkg::CH_COLON) begin
                    pr_phase  = ihex_pkg::PH_COUNT;
                    pr_digits = 3'd0;
                    pr_field  = 16'd0;
                    pr_sum    = 8'd0;
                end else if (ch != ihex_pkg::CH_CR && ch != ihex_pkg::CH_LF) begin
                    pr_phase = ihex_pkg::PH_DONE;
                    r.status = ihex_pkg::ST_SEQERR;
                end
            end
            ihex_pkg::PH_COUNT: begin
                if (nib[4] && shift_digit(nib[3:0], 3'd2)) begin
                    pr_left   = pr_field[7:0];
                    pr_sum    = pr_sum + pr_left;
                    pr_phase  = ihex_pkg::PH_ADDR;
                    pr_digits = 3'd0;
                    pr_field  = 16'd0;
                end
            end
            ihex_pkg::PH_ADDR: begin
                if (nib[4] && shift_digit(nib[3:0], 3'd4)) begin
                    pr_addr   = pr_field;
                    pr_sum    = pr_sum + pr_field[15:8] + pr_field[7:0];
                    pr_phase  = ihex_pkg::PH_TYPE;
                    pr_digits = 3'd0;
                    pr_field  = 16'd0;
                end
            end
            ihex_pkg::PH_TYPE: begin
                if (nib[4] && shift_digit(nib[3:0], 3'd2)) begin
                    b      = pr_field[7:0];
                    pr_sum = pr_sum + b;
                    if (b != 8'd0)
                        pr_phase = ihex_pkg::PH_END;
                    else if (pr_left == 8'd0)
                        pr_phase = ihex_pkg::PH_SUM;
                    else
                        pr_phase = ihex_pkg::PH_DATA;
                    pr_digits = 3'd0;
                    pr_field  = 16'd0;
                end
            end
            ihex_pkg::PH_DATA: begin
                if (nib[4] && shift_digit(nib[3:0], 3'd2)) begin
                    b               = pr_field[7:0];
                    pr_sum          = pr_sum + b;
                    r.write_valid   = 1'b1;
                    r.write_address = pr_addr;
                    r.write_data    = b;
                    pr_addr         = pr_addr + 16'd1;
                    pr_left         = pr_left - 8'd1;
                    if (pr_left == 8'd0)
                        pr_phase = ihex_pkg::PH_SUM;
                    pr_digits = 3'd0;
                    pr_field  = 16'd0;
                end
            end
            ihex_pkg::PH_SUM: begin
                if (nib[4] && shift_digit(nib[3:0], 3'd2)) begin
                    total = pr_sum + pr_field[7:0];
                    if (total != 8'd0) begin
                        pr_phase = ihex_pkg::PH_DONE;
                        r.status = ihex_pkg::ST_SUMERR;
                    end else begin
                        pr_phase = ihex_pkg::PH_START;
                        pr_left  = 8'd0;
                        pr_addr  = 16'd0;
                        pr_sum   = 8'd0;
                    end
                    pr_digits = 3'd0;
                    pr_field  = 16'd0;
                end
            end
            ihex_pkg::PH_END: begin
                if (nib[4] && shift_digit(nib[3:0], 3'd2)) begin
                    pr_phase  = ihex_pkg::PH_DONE;
                    r.status  = ihex_pkg::ST_DONE;
                    pr_digits = 3'd0;
                    pr_field  = 16'd0;
                end
            end
            default: begin
                pr_phase = ihex_pkg::PH_DONE;
                r.status = pr_last;
            end
        endcase
        pr_last = r.status;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stream builder
    // ------------------------------------------------------------------------

    task automatic add_char(input logic [7:0] ch);
        char_item_t item;
        item.ch    = ch;
        item.drain = drain_next;
        drain_next = 1'b0;
        char_q.push_back(item);
    endtask

    // any byte that is not a hex digit, the full 8-bit range
    function automatic logic [7:0] non_hex_char();
        logic [7:0] ch;
        ch = 8'($urandom_range(0, 255));
        while (digit_of(ch) != 5'd0)
            ch = 8'($urandom_range(0, 255));
        return ch;
    endfunction

    // one digit in random case, sometimes preceded by junk
    task automatic add_nibble(input logic [3:0] n);
        logic [7:0] base;
        if ($urandom_range(0, 99) < filler_pct)
            add_char(non_hex_char());
        base = $urandom_range(0, 1) ? "A" : "a";
        add_char(n < 4'd10 ? "0" + 8'(n) : base + 8'(n) - 8'd10);
    endtask

    task automatic add_byte(input logic [7:0] b);
        add_nibble(b[7:4]);
        add_nibble(b[3:0]);
    endtask

    task automatic add_line_breaks();
        int n;
        n = $urandom_range(0, 3);
        repeat (n)
            add_char($urandom_range(0, 1) ? ihex_pkg::CH_CR : ihex_pkg::CH_LF);
    endtask

    task automatic add_record(input logic [7:0] count, input logic [15:0] addr,
                              input logic [7:0] rtype, input bit bad_sum);
        logic [7:0] sum;
        logic [7:0] b;
        add_char(ihex_pkg::CH_COLON);
        add_byte(count);
        add_byte(addr[15:8]);
        add_byte(addr[7:0]);
        add_byte(rtype);
        sum = count + addr[15:8] + addr[7:0] + rtype;
        if (rtype != 8'd0) begin
            // end record: two trailing digits, never checked
            add_byte(8'($urandom_range(0, 255)));
        end else begin
            for (int i = 0; i < count; i++) begin
                b   = 8'($urandom_range(0, 255));
                sum = sum + b;
                add_byte(b);
            end
            sum = 8'd0 - sum;
            if (bad_sum)
                sum = sum ^ 8'($urandom_range(1, 255));
            add_byte(sum);
        end
        record_count++;
    endtask

    task automatic add_data_record(input logic [7:0] count, input logic [15:0] addr,
                                   input logic [7:0] d0, input logic [7:0] d1);
        logic [7:0] sum;
        add_char(ihex_pkg::CH_COLON);
        add_byte(count);
        add_byte(addr[15:8]);
        add_byte(addr[7:0]);
        add_byte(8'd0);
        add_byte(d0);
        add_byte(d1);
        sum = count + addr[15:8] + addr[7:0] + d0 + d1;
        add_byte(8'd0 - sum);
        record_count++;
    endtask

    task automatic build_stream();
        logic [7:0]  count;
        logic [15:0] addr;
        logic [7:0]  ch;
        // directed: line breaks, zero count at the top address with a stray
        // character, then two bytes that wrap the address
        filler_pct = 0;
        add_char(ihex_pkg::CH_CR);
        add_char(ihex_pkg::CH_LF);
        add_char(ihex_pkg::CH_COLON);
        add_byte(8'h00);
        add_char(8'hc7);
        add_byte(8'hff);
        add_byte(8'hff);
        add_byte(8'h00);
        add_byte(8'h02);
        record_count++;
        add_data_record(8'd2, 16'hffff, 8'h00, 8'hff);
        add_line_breaks();

        // random well-formed records, the sender drains first
        filler_pct = 8;
        drain_next = 1'b1;
        while (char_q.size() < RANDOM_TARGET) begin
            if ($urandom_range(0, 99) < 3)
                count = 8'd255;
            else if ($urandom_range(0, 9) == 0)
                count = 8'($urandom_range(13, 40));
            else
                count = 8'($urandom_range(0, 12));
            if ($urandom_range(0, 9) == 0)
                addr = 16'hfff0 + 16'($urandom_range(0, 15));
            else
                addr = 16'($urandom_range(0, 65535));
            // one more full drain partway through
            if (char_q.size() > 800 && char_q.size() < 830)
                drain_next = 1'b1;
            add_record(count, addr, 8'd0, 1'b0);
            add_line_breaks();
        end

        // terminate the stream
        stream_end = stream_end_t'($urandom_range(0, 2));
        case (stream_end)
            END_RECORD:
                add_record(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                           8'($urandom_range(1, 255)), 1'b0);
            END_BAD_SUM:
                add_record(8'($urandom_range(0, 8)), 16'($urandom_range(0, 65535)),
                           8'd0, 1'b1);
            default: begin
                ch = 8'($urandom_range(0, 255));
                while (ch == ihex_pkg::CH_COLON || ch == ihex_pkg::CH_CR
                        || ch == ihex_pkg::CH_LF)
                    ch = 8'($urandom_range(0, 255));
                add_char(ch);
            end
        endcase

        // noise after the end, status must hold
        repeat (40)
            add_char(8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        int idle_pct;
        bit offer;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            // accepted transaction: predict its result
            if (s_valid && s_ready) begin
                expected_q.push_back(predict_char(s_character));
                chars_sent++;
            end
            if (!(s_valid && !s_ready)) begin
                case ((chars_sent / PHASE_LEN) % 4)
                    1:       idle_pct = 45;
                    3:       idle_pct = 33;
                    default: idle_pct = 0;
                endcase
                offer = 1'b0;
                if (char_q.size() > 0) begin
                    if (char_q[0].drain && chars_sent != results_seen)
                        offer = 1'b0;
                    else
                        offer = $urandom_range(0, 99) >= idle_pct;
                end
                if (offer) begin
                    s_valid     <= 1'b1;
                    s_character <= char_q[0].ch;
                    char_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [15:0] expv,
                                 input logic [15:0] actv);
        if (expv !== actv) begin
            $display("%0t: %s expected %0h actual %0h", $realtime, name, expv, actv);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        parse_result_t want;
        int            stall_pct;
        int            hold_left;
        bit            hold_done;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end else begin
            // accepted result transaction
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                last_seen_status = m_status;
                if (m_write_valid === 1'b1)
                    writes_seen++;
                if (expected_q.size() == 0) begin
                    $display("%0t: result with nothing expected, status %0h",
                             $realtime, m_status);
                    error_count++;
                end else begin
                    want = expected_q.pop_front();
                    compare_field("status", 16'(want.status), 16'(m_status));
                    compare_field("write_valid", 16'(want.write_valid), 16'(m_write_valid));
                    compare_field("write_address", want.write_address, m_write_address);
                    compare_field("write_data", 16'(want.write_data), 16'(m_write_data));
                end
            end
            // one long hold-off so the input side backs up
            if (!hold_done && results_seen >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            case ((results_seen / PHASE_LEN) % 4)
                2:       stall_pct = 45;
                3:       stall_pct = 33;
                default: stall_pct = 0;
            endcase
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= $urandom_range(0, 99) >= stall_pct;
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        int quiet_cycles;
        if (!aresetn) begin
            quiet_cycles = 0;
        end else begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
                $display("intel_hex_record_parser: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        pr_phase  = ihex_pkg::PH_START;
        pr_digits = 3'd0;
        pr_field  = 16'd0;
        pr_left   = 8'd0;
        pr_addr   = 16'd0;
        pr_sum    = 8'd0;
        pr_last   = ihex_pkg::ST_DONE;
        build_stream();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (char_q.size() != 0 || s_valid || expected_q.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (expected_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $realtime, expected_q.size());
            error_count++;
        end

        $display("run covered %0d characters in %0d records, %0d byte writes checked",
                 chars_sent, record_count, writes_seen);
        $display("stream terminated by %s, final status %0d",
                 stream_end.name(), last_seen_status);
        if (error_count == 0)
            $display("intel_hex_record_parser: match");
        else
            $display("intel_hex_record_parser: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
+incdir+rtl/core
rtl/core/ihex_pkg.sv
rtl/core/intel_hex_record_parser.sv
rtl/core/ihex_checker.sv
tb/sv/tb_top.sv
